/* hdl/wcbs_pkg.sv */
// shared types and constants for the wildcard byte signature scanner
`default_nettype none

package wcbs_pkg;

    // function codes carried in s_axis_tuser
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_SCAN = 2'd1;
    localparam logic [1:0] FUNC_EOI  = 2'd2;

    // report kinds carried in m_axis_tuser
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] CNT_ZERO = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // input tdata layout
    localparam int IN_TDATA_W   = 64;
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_VAL_LSB   = 7;
    localparam int IN_CARE_BIT  = 15;
    localparam int IN_BYTE_LSB  = 16;
    localparam int IN_ADDR_LSB  = 24;
    localparam int IN_FIRST_BIT = 56;

    // output tdata layout
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_CNT_LSB  = 32;
    localparam int OUT_UNIQ_BIT = 34;

    // reduction group size in the match tree
    localparam int GROUP_W = 16;

    typedef struct packed {
        logic [7:0] value;
        logic       care;
    } pat_entry_t;

    typedef struct packed {
        logic shift;
        logic rot_up;
        logic rot_dn;
    } cell_ctl_t;

    typedef struct packed {
        logic        eoi;
        logic        filled;
        logic [31:0] start;
    } rep_item_t;

endpackage

`default_nettype wire

/* hdl/wcbs_cell.sv */
// one window cell: a window byte, an aligned pattern entry and its compare
`default_nettype none

module wcbs_cell (
    input  wire                      clk,
    input  wcbs_pkg::cell_ctl_t      ctl,
    input  wire                      load_en,
    input  wcbs_pkg::pat_entry_t     load_entry,
    input  wire  [7:0]               win_in,
    input  wcbs_pkg::pat_entry_t     pat_up_in,
    input  wcbs_pkg::pat_entry_t     pat_dn_in,
    output logic [7:0]               win_out,
    output wcbs_pkg::pat_entry_t     pat_out,
    output logic                     eq
);

    logic [7:0]           win_reg;
    wcbs_pkg::pat_entry_t pat_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            win_reg <= win_in;
        end
    end

    // pattern ring: loads land here, realignment rotates through neighbors
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            pat_reg <= load_entry;
        end
        else if (ctl.rot_up)
        begin
            pat_reg <= pat_up_in;
        end
        else if (ctl.rot_dn)
        begin
            pat_reg <= pat_dn_in;
        end
    end

    // compare against the byte that enters this cell on the shift
    assign eq      = !pat_reg.care || (win_in == pat_reg.value);
    assign win_out = win_reg;
    assign pat_out = pat_reg;

endmodule

`default_nettype wire

/* hdl/wcbs_report.sv */
// match tree reduction, hit counting and output register
`default_nettype none

module wcbs_report #(
    parameter int MAX_PATTERN = 128
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wcbs_pkg::rep_item_t      in_item,
    input  wire  [MAX_PATTERN-1:0]   in_eq,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic                     out_kind,
    output logic [31:0]              out_address,
    output logic [1:0]               out_count,
    output logic                     out_unique
);

    localparam int NGRP = (MAX_PATTERN + wcbs_pkg::GROUP_W - 1) / wcbs_pkg::GROUP_W;

    logic                s2_valid_reg;
    wcbs_pkg::rep_item_t s2_item_reg;
    logic [NGRP-1:0]     s2_grp_reg;
    logic [NGRP-1:0]     grp_next;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [31:0] out_address_reg;
    logic [1:0]  out_count_reg;
    logic        out_unique_reg;

    logic [1:0]  found_reg;
    logic [1:0]  found_next;
    logic [31:0] first_reg;
    logic [31:0] first_next;

    logic out_free;
    logic s2_take;
    logic hit;
    logic emit;

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = 1'b1;
            for (int j = 0; j < wcbs_pkg::GROUP_W; j++)
            begin
                if (g * wcbs_pkg::GROUP_W + j < MAX_PATTERN)
                begin
                    grp_next[g] = grp_next[g] & in_eq[g * wcbs_pkg::GROUP_W + j];
                end
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign s2_take  = s2_valid_reg && out_free;
    assign in_ready = !s2_valid_reg || out_free;

    assign hit  = !s2_item_reg.eoi && s2_item_reg.filled && (&s2_grp_reg);
    assign emit = s2_take && (s2_item_reg.eoi || hit);

    always_comb
    begin
        found_next = found_reg;
        first_next = first_reg;
        if (s2_take && s2_item_reg.eoi)
        begin
            found_next = wcbs_pkg::CNT_ZERO;
            first_next = '0;
        end
        else if (s2_take && hit)
        begin
            if (found_reg == wcbs_pkg::CNT_ZERO)
            begin
                first_next = s2_item_reg.start;
            end
            if (found_reg != wcbs_pkg::CNT_TWO)
            begin
                found_next = found_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= wcbs_pkg::CNT_ZERO;
            first_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s2_valid_reg <= in_valid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            found_reg <= found_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s2_item_reg <= in_item;
            s2_grp_reg  <= grp_next;
        end
        if (emit)
        begin
            if (s2_item_reg.eoi)
            begin
                out_kind_reg    <= wcbs_pkg::KIND_VERDICT;
                out_address_reg <= first_reg;
                out_count_reg   <= found_reg;
                out_unique_reg  <= (found_reg == wcbs_pkg::CNT_ONE);
            end
            else
            begin
                out_kind_reg    <= wcbs_pkg::KIND_MATCH;
                out_address_reg <= s2_item_reg.start;
                out_count_reg   <= found_next;
                out_unique_reg  <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_address = out_address_reg;
    assign out_count   = out_count_reg;
    assign out_unique  = out_unique_reg;

endmodule

`default_nettype wire

/* hdl/wildcard_byte_signature_scan.sv */
// top level: wildcard byte signature scanner built from a chain of window cells
// a result moves through the stage 1, stage 2 and output registers before it leaves on m_axis
// throughput: one item per cycle unless m_axis stalls or the ring realigns; every cell
//   compares in parallel, the match tree is registered in two stages behind the cell row
// a pattern length write realigns the pattern ring by one cell per cycle of
//   length change, holding off both s_axis and cfg until aligned
// reset (rst_n low, asynchronous) clears control, counts and length to 1
`default_nettype none

module wildcard_byte_signature_scan #(
    parameter int MAX_PATTERN  = 128,
    parameter int ADDRESS_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    // tdata: entry_index[6:0], entry_value[14:7], entry_care[15], data_byte[23:16],
    //        byte_address[55:24], first_in_section[56], zero fill
    input  wire  [63:0] s_axis_tdata,
    // tuser: func[1:0]
    input  wire  [1:0]  s_axis_tuser,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: match_address[31:0], match_count[33:32], unique_match[34], zero fill
    output logic [39:0] m_axis_tdata,
    // tuser: report_kind[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [7:0]  cfg_data,
    input  wire         cfg_valid,
    output logic        cfg_ready
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CW    = (LEN_W > 8) ? LEN_W : 8;
    localparam int AW    = ((IDX_W > 7) ? IDX_W : 7) + 1;
    localparam logic [63:0] ADDR_MASK =
        (ADDRESS_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << ADDRESS_BITS) - 64'd1);

    // input fields
    logic [1:0]  func;
    logic [6:0]  entry_index;
    logic [7:0]  entry_value;
    logic        entry_care;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        first_in_section;

    assign func             = s_axis_tuser;
    assign entry_index      = s_axis_tdata[wcbs_pkg::IN_IDX_LSB +: 7];
    assign entry_value      = s_axis_tdata[wcbs_pkg::IN_VAL_LSB +: 8];
    assign entry_care       = s_axis_tdata[wcbs_pkg::IN_CARE_BIT];
    assign data_byte        = s_axis_tdata[wcbs_pkg::IN_BYTE_LSB +: 8];
    assign byte_address     = s_axis_tdata[wcbs_pkg::IN_ADDR_LSB +: 32];
    assign first_in_section = s_axis_tdata[wcbs_pkg::IN_FIRST_BIT];

    // pattern length: target from cfg, current is what the ring is aligned to
    logic [LEN_W-1:0] len_target_reg;
    logic [LEN_W-1:0] len_cur_reg;
    logic [CW-1:0]    cfg_x;
    logic [LEN_W-1:0] cfg_len;
    logic             aligned;

    assign cfg_x   = CW'(cfg_data);
    assign aligned = (len_cur_reg == len_target_reg);
    assign cfg_ready = aligned;

    always_comb
    begin
        if (cfg_x == '0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if (cfg_x > CW'(MAX_PATTERN))
        begin
            cfg_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            cfg_len = cfg_x[LEN_W-1:0];
        end
    end

    // handshake and stage 1
    logic                s1_valid_reg;
    wcbs_pkg::rep_item_t s1_item_reg;
    logic [MAX_PATTERN-1:0] s1_eq_reg;
    logic                rep_ready;
    logic                s1_ready;
    logic                in_xfer;
    logic                is_scan;
    logic                is_eoi;
    logic                is_load;

    assign s1_ready      = !s1_valid_reg || rep_ready;
    assign s_axis_tready = s1_ready && aligned;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_scan       = in_xfer && (func == wcbs_pkg::FUNC_SCAN);
    assign is_eoi        = in_xfer && (func == wcbs_pkg::FUNC_EOI);
    assign is_load       = in_xfer && (func == wcbs_pkg::FUNC_LOAD);

    // window fill
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_base;
    logic [LEN_W-1:0] fill_next;

    assign fill_base = first_in_section ? '0 : fill_reg;
    assign fill_next = (fill_base == LEN_W'(MAX_PATTERN)) ? fill_base : fill_base + LEN_W'(1);

    // match start address
    logic [63:0] start64;
    assign start64 = ({32'd0, byte_address} - 64'(len_cur_reg - LEN_W'(1))) & ADDR_MASK;

    // cell that holds pattern position entry_index: (len - 1 - index) mod MAX_PATTERN
    logic [AW-1:0]    lm1;
    logic [AW-1:0]    kx;
    logic [AW-1:0]    diff;
    logic [AW-1:0]    wrapped;
    logic [IDX_W-1:0] load_addr;
    logic             load_ok;

    assign lm1       = AW'(len_cur_reg - LEN_W'(1));
    assign kx        = AW'(entry_index);
    assign diff      = lm1 - kx;
    assign wrapped   = diff[AW-1] ? diff + AW'(MAX_PATTERN) : diff;
    assign load_addr = wrapped[IDX_W-1:0];
    assign load_ok   = is_load && (kx < AW'(MAX_PATTERN));

    // cell row
    wcbs_pkg::cell_ctl_t  ctl;
    wcbs_pkg::pat_entry_t load_entry;
    logic [7:0]           win_out [MAX_PATTERN];
    wcbs_pkg::pat_entry_t pat_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN-1:0] eq_masked;

    assign ctl.shift        = is_scan;
    assign ctl.rot_up       = len_cur_reg < len_target_reg;
    assign ctl.rot_dn       = len_cur_reg > len_target_reg;
    assign load_entry.value = entry_value;
    assign load_entry.care  = entry_care;

    for (genvar a = 0; a < MAX_PATTERN; a++)
    begin : g_cell
        logic [7:0] win_in;
        if (a == 0)
        begin : g_head
            assign win_in = data_byte;
        end
        else
        begin : g_body
            assign win_in = win_out[a-1];
        end

        wcbs_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .load_en    (load_ok && (load_addr == IDX_W'(a))),
            .load_entry (load_entry),
            .win_in     (win_in),
            .pat_up_in  (pat_out[(a + MAX_PATTERN - 1) % MAX_PATTERN]),
            .pat_dn_in  (pat_out[(a + 1) % MAX_PATTERN]),
            .win_out    (win_out[a]),
            .pat_out    (pat_out[a]),
            .eq         (eq[a])
        );

        // cells past the active length always agree
        assign eq_masked[a] = eq[a] || (LEN_W'(a) >= len_cur_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_target_reg <= LEN_W'(1);
            len_cur_reg    <= LEN_W'(1);
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                len_target_reg <= cfg_len;
            end
            if (ctl.rot_up)
            begin
                len_cur_reg <= len_cur_reg + LEN_W'(1);
            end
            else if (ctl.rot_dn)
            begin
                len_cur_reg <= len_cur_reg - LEN_W'(1);
            end
            if (is_scan)
            begin
                fill_reg <= fill_next;
            end
            else if (is_eoi)
            begin
                fill_reg <= '0;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= is_scan || is_eoi;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_scan || is_eoi)
        begin
            s1_item_reg.eoi    <= is_eoi;
            s1_item_reg.filled <= fill_next >= len_cur_reg;
            s1_item_reg.start  <= start64[31:0];
            s1_eq_reg          <= eq_masked;
        end
    end

    // stage 2 and output
    logic        out_kind;
    logic [31:0] out_address;
    logic [1:0]  out_count;
    logic        out_unique;

    wcbs_report #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .in_ready    (rep_ready),
        .in_item     (s1_item_reg),
        .in_eq       (s1_eq_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (out_kind),
        .out_address (out_address),
        .out_count   (out_count),
        .out_unique  (out_unique)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {5'd0, out_unique, out_count, out_address};

endmodule

`default_nettype wire

/* hdl/wcbs_check.sv */
// port-level checks on the scanner's result stream, bound to the top level
`default_nettype none

module wcbs_check (
    input wire        clk,
    input wire        rst_n,
    input wire [39:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready
);

    logic        is_match;
    logic        is_verdict;
    logic [1:0]  cnt;
    logic        uniq;

    assign is_match   = m_axis_tvalid && (m_axis_tuser[0] == wcbs_pkg::KIND_MATCH);
    assign is_verdict = m_axis_tvalid && (m_axis_tuser[0] == wcbs_pkg::KIND_VERDICT);
    assign cnt        = m_axis_tdata[wcbs_pkg::OUT_CNT_LSB +: 2];
    assign uniq       = m_axis_tdata[wcbs_pkg::OUT_UNIQ_BIT];

    // a stalled transfer holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        is_match |-> (cnt == wcbs_pkg::CNT_ONE || cnt == wcbs_pkg::CNT_TWO) && !uniq)
        else $error("match report with bad count or unique flag");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cnt != 2'd3)
        else $error("count above saturation");

    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        is_verdict |-> (uniq == (cnt == wcbs_pkg::CNT_ONE)))
        else $error("unique flag disagrees with count");

    // after a transferred verdict the next match report counts from one
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        is_verdict && m_axis_tready ##1 is_match |-> cnt == wcbs_pkg::CNT_ONE)
        else $error("count not restarted after verdict");

endmodule

bind wildcard_byte_signature_scan wcbs_check u_wcbs_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

/* bench/wildcard_byte_signature_scan_test.sv */
// self-checking testbench for the wildcard byte signature scanner
`default_nettype none

module wildcard_byte_signature_scan_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH = 128;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  idx;
        logic [7:0]  val;
        logic        care;
        logic [7:0]  dbyte;
        logic [31:0] addr;
        logic        first;
    } scan_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [1:0]  count;
        logic        uniq;
    } report_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    wildcard_byte_signature_scan uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    // signature tracker state, mirrors the block
    logic [7:0]  sig_val   [WIN_DEPTH] = '{default: 8'h00};
    logic        sig_care  [WIN_DEPTH] = '{default: 1'b0};
    logic [7:0]  win_bytes [WIN_DEPTH] = '{default: 8'h00};
    int          win_fill = 0;
    logic [1:0]  hit_count = wcbs_pkg::CNT_ZERO;
    logic [31:0] first_hit_addr = '0;
    logic [7:0]  cur_len = 8'd1;

    // generator's view of the pattern, updated as loads are queued
    logic [7:0]  plan_val  [WIN_DEPTH] = '{default: 8'h00};
    logic        plan_care [WIN_DEPTH] = '{default: 1'b0};
    int          plan_active = 1;

    scan_item_t  items_pending[$];
    report_t     reports_due[$];
    scan_item_t  on_bus;
    logic        bus_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_tick = 0;
    rx_style_t   rx_style = RX_OPEN;
    int          errors = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("wildcard_byte_signature_scan_test: done, errors");
        $finish;
    end

    function automatic int act_len(input logic [7:0] v);
        if (v == 8'd0)
            return 1;
        if (v > WIN_DEPTH)
            return WIN_DEPTH;
        return int'(v);
    endfunction

    task automatic track_signature(input scan_item_t it);
        int      len;
        int      k;
        logic    hit;
        report_t r;
        case (it.func)
            wcbs_pkg::FUNC_LOAD:
            begin
                sig_val[it.idx]  = it.val;
                sig_care[it.idx] = it.care;
            end
            wcbs_pkg::FUNC_SCAN:
            begin
                len = act_len(cur_len);
                if (it.first)
                    win_fill = 0;
                for (k = WIN_DEPTH - 1; k > 0; k--)
                    win_bytes[k] = win_bytes[k - 1];
                win_bytes[0] = it.dbyte;
                if (win_fill < WIN_DEPTH)
                    win_fill++;
                if (win_fill >= len)
                begin
                    hit = 1'b1;
                    // pattern position 0 lines up with the oldest byte of the window
                    for (k = 0; k < len; k++)
                        if (sig_care[k] && win_bytes[len - 1 - k] != sig_val[k])
                            hit = 1'b0;
                    if (hit)
                    begin
                        r.kind = wcbs_pkg::KIND_MATCH;
                        r.addr = it.addr - 32'(len - 1);
                        if (hit_count == wcbs_pkg::CNT_ZERO)
                            first_hit_addr = r.addr;
                        if (hit_count != wcbs_pkg::CNT_TWO)
                            hit_count = hit_count + 2'd1;
                        r.count = hit_count;
                        r.uniq  = 1'b0;
                        reports_due.insert(reports_due.size(), r);
                    end
                end
            end
            wcbs_pkg::FUNC_EOI:
            begin
                r.kind  = wcbs_pkg::KIND_VERDICT;
                r.addr  = first_hit_addr;
                r.count = hit_count;
                r.uniq  = (hit_count == wcbs_pkg::CNT_ONE);
                reports_due.insert(reports_due.size(), r);
                hit_count      = wcbs_pkg::CNT_ZERO;
                first_hit_addr = '0;
                win_fill       = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // input side: prediction on the transfer, new data at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            track_signature(on_bus);
            bus_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : input_driver
        logic [wcbs_pkg::IN_TDATA_W-1:0] word;
        if (rst_n && (!s_axis_tvalid || bus_taken))
        begin
            bus_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (items_pending.size() != 0)
            begin
                on_bus = items_pending.pop_front();
                word = '0;
                word[wcbs_pkg::IN_IDX_LSB +: 7]   = on_bus.idx;
                word[wcbs_pkg::IN_VAL_LSB +: 8]   = on_bus.val;
                word[wcbs_pkg::IN_CARE_BIT]       = on_bus.care;
                word[wcbs_pkg::IN_BYTE_LSB +: 8]  = on_bus.dbyte;
                word[wcbs_pkg::IN_ADDR_LSB +: 32] = on_bus.addr;
                word[wcbs_pkg::IN_FIRST_BIT]      = on_bus.first;
                s_axis_tdata  <= word;
                s_axis_tuser  <= on_bus.func;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        burst_left = $urandom_range(40, 160);
                    else
                        burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_tick % 89 == 0)
            rx_style = rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (rx_tick % 4 == 0);
            default:   m_axis_tready <= (rx_tick % 16 >= 10);
        endcase
    end

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_monitor
        report_t want;
        report_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind  = m_axis_tuser[0];
            got.addr  = m_axis_tdata[31:0];
            got.count = m_axis_tdata[wcbs_pkg::OUT_CNT_LSB +: 2];
            got.uniq  = m_axis_tdata[wcbs_pkg::OUT_UNIQ_BIT];
            if (reports_due.size() == 0)
            begin
                errors++;
                $display({"%0t ns: unexpected report, expected none, ",
                          "got kind %0d addr 0x%0h count %0d unique %0d"},
                         $time, got.kind, got.addr, got.count, got.uniq);
            end
            else
            begin
                want = reports_due.pop_front();
                if (got.kind !== want.kind)
                    flag_field("report_kind", 32'(want.kind), 32'(got.kind));
                if (got.addr !== want.addr)
                    flag_field("match_address", want.addr, got.addr);
                if (got.count !== want.count)
                    flag_field("match_count", 32'(want.count), 32'(got.count));
                if (got.uniq !== want.uniq)
                    flag_field("unique_match", 32'(want.uniq), 32'(got.uniq));
            end
        end
    end

    function automatic scan_item_t blank_item(input logic [1:0] f);
        scan_item_t it;
        it.func  = f;
        it.idx   = 7'($urandom_range(0, 127));
        it.val   = 8'($urandom_range(0, 255));
        it.care  = 1'($urandom_range(0, 1));
        it.dbyte = 8'($urandom_range(0, 255));
        it.addr  = $urandom();
        it.first = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic push_load(input int idx, input logic [7:0] v, input logic c);
        scan_item_t it;
        it = blank_item(wcbs_pkg::FUNC_LOAD);
        it.idx  = 7'(idx);
        it.val  = v;
        it.care = c;
        plan_val[idx]  = v;
        plan_care[idx] = c;
        items_pending.insert(items_pending.size(), it);
    endtask

    task automatic push_scan(input logic [7:0] b, input logic [31:0] a, input logic f);
        scan_item_t it;
        it = blank_item(wcbs_pkg::FUNC_SCAN);
        it.dbyte = b;
        it.addr  = a;
        it.first = f;
        items_pending.insert(items_pending.size(), it);
    endtask

    task automatic push_op(input logic [1:0] f);
        items_pending.insert(items_pending.size(), blank_item(f));
    endtask

    // wait for the queue to empty and every report to come back, then let the pipe settle
    task automatic drain_and_wait();
        int waited;
        do
            @(posedge clk);
        while (items_pending.size() != 0 || s_axis_tvalid);
        waited = 0;
        while (reports_due.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        if (reports_due.size() != 0)
        begin
            errors++;
            $display("%0t ns: missing reports, expected %0d more, got none", $time,
                     reports_due.size());
            reports_due.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length(input logic [7:0] v);
        drain_and_wait();
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cur_len     = v;
        plan_active = act_len(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] reg_len, input int n_scan, input bit reload);
        int          care_pct;
        int          scanned;
        int          sec_len;
        int          i;
        int          k;
        logic [31:0] a;
        logic [7:0]  b;
        write_length(reg_len);
        case ($urandom_range(0, 3))
            0:       care_pct = 0;
            1:       care_pct = 25;
            2:       care_pct = 60;
            default: care_pct = 100;
        endcase
        if (reload || $urandom_range(0, 3) != 0)
            for (k = 0; k < plan_active; k++)
                push_load(k, 8'($urandom()), $urandom_range(0, 99) < care_pct);
        scanned = 0;
        while (scanned < n_scan)
        begin
            sec_len = $urandom_range(1, plan_active + 24);
            case ($urandom_range(0, 3))
                0:       a = $urandom_range(0, 8);
                1:       a = 32'hFFFF_FFFF - $urandom_range(0, 200);
                default: a = $urandom();
            endcase
            i = 0;
            while (i < sec_len)
            begin
                if ($urandom_range(0, 2) == 0 && i + plan_active <= sec_len)
                begin
                    // planted copy of the signature, wildcards get random bytes
                    for (k = 0; k < plan_active; k++)
                    begin
                        b = plan_care[k] ? plan_val[k] : 8'($urandom());
                        push_scan(b, a, (i == 0 && $urandom_range(0, 7) != 0) ||
                                  $urandom_range(0, 199) == 0);
                        a++;
                        i++;
                    end
                end
                else
                begin
                    if ($urandom_range(0, 1) == 1)
                        b = plan_val[$urandom_range(0, plan_active - 1)];
                    else
                        b = 8'($urandom());
                    push_scan(b, a, (i == 0 && $urandom_range(0, 7) != 0) ||
                              $urandom_range(0, 59) == 0);
                    a = ($urandom_range(0, 39) == 0) ? $urandom() : a + 32'd1;
                    i++;
                end
                case ($urandom_range(0, 79))
                    0:       push_op(FUNC_UNUSED);
                    1:       push_load($urandom_range(0, 127), 8'($urandom()),
                                       1'($urandom_range(0, 1)));
                    default:
                    begin
                    end
                endcase
            end
            scanned += i;
            if ($urandom_range(0, 3) == 0)
                push_op(wcbs_pkg::FUNC_EOI);
        end
        push_op(wcbs_pkg::FUNC_EOI);
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // reset length of one: single-byte signature, count saturation, empty verdict
        push_load(0, 8'hA5, 1'b1);
        push_load(127, 8'hFF, 1'b0);
        push_load(85, 8'h00, 1'b1);
        push_op(wcbs_pkg::FUNC_EOI);
        push_scan(8'h00, 32'h0000_0000, 1'b1);
        push_scan(8'hA5, 32'hFFFF_FFFF, 1'b0);
        push_op(wcbs_pkg::FUNC_EOI);
        push_op(FUNC_UNUSED);
        push_scan(8'hA5, 32'h0000_0010, 1'b1);
        push_scan(8'hA5, 32'h0000_0011, 1'b0);
        push_scan(8'hA5, 32'h0000_0012, 1'b0);
        push_op(wcbs_pkg::FUNC_EOI);

        // four positions with a wildcard: start address wrap, then a section break
        write_length(8'd4);
        push_load(0, 8'h11, 1'b1);
        push_load(1, 8'h22, 1'b1);
        push_load(2, 8'h00, 1'b0);
        push_load(3, 8'h44, 1'b1);
        push_scan(8'h11, 32'h0000_0100, 1'b1);
        push_scan(8'h22, 32'h0000_0101, 1'b0);
        push_scan(8'h77, 32'h0000_0102, 1'b0);
        push_scan(8'h44, 32'h0000_0001, 1'b0);
        push_scan(8'h11, 32'h0000_0200, 1'b1);
        push_scan(8'h22, 32'h0000_0201, 1'b0);
        push_scan(8'h33, 32'h0000_0202, 1'b1);
        push_scan(8'h44, 32'h0000_0203, 1'b0);
        push_op(wcbs_pkg::FUNC_EOI);

        run_phase(8'd128, 85, 1'b1);
        run_phase(8'd4,   85, 1'b0);
        run_phase(8'd0,   85, 1'b0);
        run_phase(8'd2,   85, 1'b0);
        run_phase(8'd200, 85, 1'b0);
        run_phase(8'd9,   85, 1'b0);
        run_phase(8'd1,   85, 1'b0);
        run_phase(8'd31,  85, 1'b0);
        run_phase(8'd255, 85, 1'b0);
        run_phase(8'd3,   85, 1'b0);
        run_phase(8'($urandom_range(1, 20)), 85, 1'b0);
        run_phase(8'($urandom_range(1, 128)), 85, 1'b0);

        drain_and_wait();
        if (errors == 0)
            $display("wildcard_byte_signature_scan_test: done, clean");
        else
            $display("wildcard_byte_signature_scan_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

/* wildcard_byte_signature_scan.f */
hdl/wcbs_pkg.sv
hdl/wcbs_cell.sv
hdl/wcbs_report.sv
hdl/wildcard_byte_signature_scan.sv
hdl/wcbs_check.sv
bench/wildcard_byte_signature_scan_test.sv
